// ===== design/cce_pkg.sv =====
// Package for the configurable CRC engine.
// Register map codes, reset values and the bit-reversal helper.
// No dependencies.
package cce_pkg;

    localparam int unsigned REG_IDX_W = 3;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_CRC_WIDTH      = 3'd0;
    localparam t_reg_idx REG_POLYNOMIAL     = 3'd1;
    localparam t_reg_idx REG_INITIAL_VALUE  = 3'd2;
    localparam t_reg_idx REG_REFLECT_INPUT  = 3'd3;
    localparam t_reg_idx REG_REFLECT_OUTPUT = 3'd4;
    localparam t_reg_idx REG_FINAL_XOR      = 3'd5;

    localparam logic [5:0]  RST_CRC_WIDTH  = 6'd32;
    localparam logic [31:0] RST_POLYNOMIAL = 32'h04C1_1DB7;
    localparam logic [31:0] RST_INITIAL    = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_FINAL_XOR  = 32'hFFFF_FFFF;

    function automatic logic [31:0] rev32(input logic [31:0] x);
        logic [31:0] y;
        for (int k = 0; k < 32; k++) begin
            y[k] = x[31-k];
        end
        return y;
    endfunction

endpackage

// ===== design/configurable_crc_engine.sv =====
// Configurable CRC engine top level: APB register file, input beat register,
// single-pass byte update and result register.
// Depends on cce_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one message byte per beat
//   with i_has_byte and i_is_last. A beat with i_is_last produces one result
//   beat on the output channel (o_out_valid / i_out_stall) holding the
//   finalized CRC, right-aligned; unsupported widths give zero.
//   Result path: a final beat is held in the input beat register, then its
//   CRC is registered in the result register when the output is free.
//   Throughput: one byte per cycle unless a final beat waits on the output;
//   the eight shift-and-XOR steps of a byte are done in one pass between the
//   input beat and CRC registers, so a beat can follow every cycle.
//   Stall: while i_out_stall holds a result, non-final bytes keep flowing;
//   the next final beat waits in the input register and raises o_in_stall.
//   Reset: configuration returns to CRC-32 defaults, no message is open,
//   both beat registers are empty. Configuration must be written by the user
//   through the APB port while the block is idle; it is not enforced.
module configurable_crc_engine
    import cce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_crc_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0]  r_width;
    logic [31:0] r_poly;
    logic [31:0] r_init;
    logic        r_refl_in;
    logic        r_refl_out;
    logic [31:0] r_xor;

    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_has;
    logic        r_s1_last;

    logic [31:0] r_crc;
    logic        r_in_msg;
    logic        r_out_valid;
    logic [31:0] r_out_crc;

    logic        n_s1_valid;
    logic        n_out_valid;
    logic [31:0] n_crc;
    logic [31:0] n_out_crc;

    logic        cfg_wr;
    t_reg_idx    cfg_idx;
    logic        out_free;
    logic        s1_adv;
    logic        in_acc;
    logic        s1_act;

    logic [31:0] mask;
    logic [5:0]  sh;
    logic        w_ok;
    logic [31:0] crc_cur;
    logic [31:0] rp;
    logic [31:0] p_msb;
    logic [31:0] r_lsb_v;
    logic [31:0] r_msb_v;
    logic [31:0] b_rev;
    logic [7:0]  b_in;
    logic [31:0] v_fin;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_comb begin
        unique case (cfg_idx)
            REG_CRC_WIDTH:      prdata = {26'd0, r_width};
            REG_POLYNOMIAL:     prdata = r_poly;
            REG_INITIAL_VALUE:  prdata = r_init;
            REG_REFLECT_INPUT:  prdata = {31'd0, r_refl_in};
            REG_REFLECT_OUTPUT: prdata = {31'd0, r_refl_out};
            REG_FINAL_XOR:      prdata = r_xor;
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= RST_CRC_WIDTH;
            r_poly     <= RST_POLYNOMIAL;
            r_init     <= RST_INITIAL;
            r_refl_in  <= 1'b1;
            r_refl_out <= 1'b1;
            r_xor      <= RST_FINAL_XOR;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_CRC_WIDTH:      r_width    <= pwdata[5:0];
                REG_POLYNOMIAL:     r_poly     <= pwdata;
                REG_INITIAL_VALUE:  r_init     <= pwdata;
                REG_REFLECT_INPUT:  r_refl_in  <= pwdata[0];
                REG_REFLECT_OUTPUT: r_refl_out <= pwdata[0];
                REG_FINAL_XOR:      r_xor      <= pwdata;
                default: ;
            endcase
        end
    end

    // beat flow
    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_adv      = r_s1_valid && (!r_s1_last || out_free);
    assign o_in_stall  = r_s1_valid && !s1_adv;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign s1_act      = s1_adv && (r_s1_has || r_s1_last);
    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_out_crc;

    // byte update
    always_comb begin
        mask    = (r_width >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << r_width) - 32'd1);
        sh      = 6'd32 - r_width;
        w_ok    = (r_width >= 6'd4 && r_width <= 6'd8) || r_width == 6'd16
                  || r_width == 6'd32;
        crc_cur = r_in_msg ? r_crc : (r_init & mask);

        rp      = rev32(r_poly & mask) >> sh;
        r_lsb_v = (crc_cur & mask) ^ {24'd0, r_s1_byte};
        for (int k = 0; k < 8; k++) begin
            r_lsb_v = r_lsb_v[0] ? ((r_lsb_v >> 1) ^ rp) : (r_lsb_v >> 1);
        end

        p_msb   = (r_poly & mask) << sh;
        b_rev   = rev32({24'd0, r_s1_byte});
        b_in    = (r_width >= 6'd8 && r_refl_in) ? b_rev[31:24] : r_s1_byte;
        r_msb_v = ((crc_cur & mask) << sh) ^ {b_in, 24'd0};
        for (int k = 0; k < 8; k++) begin
            r_msb_v = r_msb_v[31] ? ((r_msb_v << 1) ^ p_msb) : (r_msb_v << 1);
        end

        n_crc = crc_cur;
        if (r_s1_has && w_ok) begin
            if (r_width < 6'd8 && r_refl_in) begin
                n_crc = r_lsb_v & mask;
            end else begin
                n_crc = (r_msb_v >> sh) & mask;
            end
        end

        v_fin = n_crc & mask;
        if (r_width >= 6'd8 && r_refl_out) begin
            v_fin = rev32(v_fin) >> sh;
        end
        n_out_crc = w_ok ? ((v_fin ^ r_xor) & mask) : 32'd0;
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_acc) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid && i_out_stall;
        if (s1_act && r_s1_last) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_in_msg    <= 1'b0;
            r_crc       <= 32'd0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (s1_act) begin
                r_crc    <= n_crc;
                r_in_msg <= !r_s1_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_byte <= i_data_byte;
            r_s1_has  <= i_has_byte;
            r_s1_last <= i_is_last;
        end
        if (s1_act && r_s1_last) begin
            r_out_crc <= n_out_crc;
        end
    end

endmodule
